// ===== rtl/wavetable_write_with_index_modes_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable write block
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_WRITE_WITH_INDEX_MODES_DEFINES_SVH
`define WAVETABLE_WRITE_WITH_INDEX_MODES_DEFINES_SVH

`ifndef SYNTHESIS

// expression holds at every edge
`define WWIM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wwim assertion failed");

// same-cycle implication
`define WWIM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wwim implication failed");

// next-cycle implication
`define WWIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wwim next-cycle check failed");

`else

`define WWIM_ASSERT_ALWAYS(label, expr)
`define WWIM_ASSERT_IMPL(label, ante, cons)
`define WWIM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/wwim_pkg.sv =====
// ----------------------------------------------------------------------------
// wwim_pkg
// Types and constants shared by the wavetable write block and its interfaces.
// ----------------------------------------------------------------------------
package wwim_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int LEN_W       = $clog2(TABLE_DEPTH) + 1;  // holds 1..TABLE_DEPTH
  localparam int REM_W       = LEN_W - 1;                // remainder < length
  localparam int ADDR_W      = LEN_W;                    // includes guard entry
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 32;                       // Q16.16
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = IDX_W + LEN_W + 1;
  localparam int FL_W        = PROD_W - FRAC_W;          // floored position
  localparam int DIV_STAGES  = 6;
  localparam int DIV_STEPS   = (FL_W + DIV_STAGES - 1) / DIV_STAGES;  // bits per stage
  localparam int MAG_W       = DIV_STAGES * DIV_STEPS;   // magnitude, zero padded
  localparam int NUM_STAGES  = DIV_STAGES + 4;           // A, B, C, divider, output
  localparam int OUT_STG     = NUM_STAGES - 1;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    MODE_LIMIT = 2'd0,
    MODE_WRAP  = 2'd1,
    MODE_GUARD = 2'd2
  } index_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH     = 2'd0,
    REG_INDEX_NORMALIZED = 2'd1,
    REG_WRITE_OFFSET     = 2'd2,
    REG_INDEX_MODE       = 2'd3
  } cfg_reg_t;

  // state carried through the remainder pipeline
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [REM_W-1:0]  rem;
    logic              neg;
    logic              err;
    logic [ADDR_W-1:0] clamp;
    logic [DATA_W-1:0] value;
  } div_t;

endpackage

// ===== rtl/wwim_ifs.sv =====
// ----------------------------------------------------------------------------
// wwim channel interfaces
// Sample input, write result and configuration write channels.
// ----------------------------------------------------------------------------
interface wwim_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wwim_pkg::IDX_W-1:0]   sample_index;
  logic        [wwim_pkg::DATA_W-1:0]  sample_value;

  modport source (output valid, sample_index, sample_value, input ready);
  modport sink   (input valid, sample_index, sample_value, output ready);
endinterface

interface wwim_result_if;
  logic                               valid;
  logic                               ready;
  logic [wwim_pkg::ADDR_W-1:0]        write_address;
  logic                               guard_written;
  logic                               status;

  modport source (output valid, write_address, guard_written, status, input ready);
  modport sink   (input valid, write_address, guard_written, status, output ready);
endinterface

interface wwim_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wwim_pkg::CFG_IDX_W-1:0]     index;
  logic [wwim_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wavetable_write_with_index_modes.sv =====
// One sample per cycle while the receiver takes results; a guard-point write
// holds the output stage while its guard copy is stored (single write port).
// The wrap remainder comes from a 6-stage restoring pipeline, 5 bits per stage.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults;
// the table contents stay undefined until written.
// ----------------------------------------------------------------------------
// wavetable_write_with_index_modes
// Maps a Q16.16 write position to a table entry (limit, wrap or guard point)
// and stores the sample word there.
// ----------------------------------------------------------------------------
`include "wavetable_write_with_index_modes_defines.svh"

module wavetable_write_with_index_modes (
  input  logic           clk,
  input  logic           rst,
  wwim_sample_if.sink    sample_in,
  wwim_result_if.source  result_out,
  wwim_cfg_if.sink       cfg
);

  // configuration
  logic [wwim_pkg::LEN_W-1:0]         len;
  logic                               index_normalized;
  logic signed [wwim_pkg::IDX_W-1:0]  write_offset;
  logic [1:0]                         index_mode;

  // pipeline control
  logic [wwim_pkg::NUM_STAGES-1:0]    v;
  logic [wwim_pkg::NUM_STAGES-1:0]    free;
  logic [wwim_pkg::NUM_STAGES-1:0]    src_v;
  logic [wwim_pkg::NUM_STAGES-1:0]    ld;

  // stage A: products
  logic signed [wwim_pkg::PROD_W-1:0] a_pidx;
  logic signed [wwim_pkg::PROD_W-1:0] a_poff;
  logic [wwim_pkg::DATA_W-1:0]        a_value;

  // stage B: floored position
  logic signed [wwim_pkg::FL_W-1:0]   b_fl;
  logic                               b_err;
  logic [wwim_pkg::DATA_W-1:0]        b_value;

  // stage C and remainder stages
  wwim_pkg::div_t                     c_st;
  wwim_pkg::div_t                     d_st [wwim_pkg::DIV_STAGES];
  wwim_pkg::div_t                     d_in [wwim_pkg::DIV_STAGES];
  wwim_pkg::div_t                     d_out[wwim_pkg::DIV_STAGES];
  wwim_pkg::div_t                     c_next;

  // output stage
  logic [wwim_pkg::ADDR_W-1:0]        out_addr;
  logic                               out_guard;
  logic                               out_status;
  logic [wwim_pkg::ADDR_W-1:0]        out_addr_next;
  logic                               out_guard_next;
  logic [wwim_pkg::ADDR_W-1:0]        wrapped;

  // guard-point write pending
  logic                               gpend;
  logic [wwim_pkg::ADDR_W-1:0]        gaddr;
  logic [wwim_pkg::DATA_W-1:0]        gdata;

  // datapath temporaries
  logic [wwim_pkg::LEN_W-1:0]         mul;
  logic signed [wwim_pkg::PROD_W-1:0] idx_x;
  logic signed [wwim_pkg::PROD_W-1:0] off_x;
  logic signed [wwim_pkg::PROD_W-1:0] mul_x;
  logic signed [wwim_pkg::PROD_W-1:0] len_q;
  logic signed [wwim_pkg::PROD_W-1:0] rnd;
  logic signed [wwim_pkg::PROD_W-1:0] ndx;
  logic [wwim_pkg::FL_W-1:0]          len_fl;
  logic [wwim_pkg::FL_W-1:0]          b_mag;
  logic [wwim_pkg::LEN_W-1:0]         cfg_len;

  logic [wwim_pkg::DATA_W-1:0]        table_store [wwim_pkg::TABLE_DEPTH + 1];

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_len = cfg.data[wwim_pkg::LEN_W-1:0];
    if (cfg_len == '0) begin
      cfg_len = wwim_pkg::LEN_W'(1);
    end else if (cfg_len > wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH)) begin
      cfg_len = wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len              <= wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH);
      index_normalized <= 1'b0;
      write_offset     <= '0;
      index_mode       <= wwim_pkg::MODE_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        wwim_pkg::REG_TABLE_LENGTH:     len              <= cfg_len;
        wwim_pkg::REG_INDEX_NORMALIZED: index_normalized <= cfg.data[0];
        wwim_pkg::REG_WRITE_OFFSET:     write_offset     <= $signed(cfg.data);
        wwim_pkg::REG_INDEX_MODE:       index_mode       <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage refills as soon as it moves on
  // --------------------------------------------------------------------------
  always_comb begin
    free[wwim_pkg::OUT_STG] = (!v[wwim_pkg::OUT_STG] || result_out.ready) && !gpend;
    for (int k = wwim_pkg::OUT_STG - 1; k >= 0; k--) begin
      free[k] = !v[k] || free[k+1];
    end
    src_v[0] = sample_in.valid;
    for (int k = 1; k < wwim_pkg::NUM_STAGES; k++) begin
      src_v[k] = v[k-1];
    end
    ld = src_v & free;
  end

  assign sample_in.ready = free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < wwim_pkg::OUT_STG; k++) begin
        if (free[k]) begin
          v[k] <= src_v[k];
        end
      end
      v[wwim_pkg::OUT_STG] <= ld[wwim_pkg::OUT_STG] ||
                              (v[wwim_pkg::OUT_STG] && !result_out.ready);
    end
  end

  // --------------------------------------------------------------------------
  // stage A: scale index and offset
  // --------------------------------------------------------------------------
  always_comb begin
    mul   = index_normalized ? len : wwim_pkg::LEN_W'(1);
    idx_x = wwim_pkg::PROD_W'(sample_in.sample_index);
    off_x = wwim_pkg::PROD_W'(write_offset);
    mul_x = $signed({{(wwim_pkg::PROD_W - wwim_pkg::LEN_W){1'b0}}, mul});
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_pidx  <= idx_x * mul_x;
      a_poff  <= off_x * mul_x;
      a_value <= sample_in.sample_value;
    end
  end

  // --------------------------------------------------------------------------
  // stage B: offset range check, sum, rounding, floor
  // --------------------------------------------------------------------------
  always_comb begin
    len_q = $signed({{(wwim_pkg::PROD_W - wwim_pkg::LEN_W - wwim_pkg::FRAC_W){1'b0}},
                     len, {wwim_pkg::FRAC_W{1'b0}}});
    rnd   = (index_mode == wwim_pkg::MODE_GUARD) ?
            $signed({{(wwim_pkg::PROD_W - wwim_pkg::FRAC_W){1'b0}}, 1'b1,
                     {(wwim_pkg::FRAC_W - 1){1'b0}}}) : '0;
    ndx   = a_pidx + a_poff + rnd;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b_fl    <= ndx[wwim_pkg::PROD_W-1:wwim_pkg::FRAC_W];  // arithmetic shift = floor
      b_err   <= a_poff[wwim_pkg::PROD_W-1] || (a_poff > len_q);
      b_value <= a_value;
    end
  end

  // --------------------------------------------------------------------------
  // stage C: clamp for limit mode, sign and magnitude for the remainder
  // --------------------------------------------------------------------------
  always_comb begin
    len_fl       = {{(wwim_pkg::FL_W - wwim_pkg::LEN_W){1'b0}}, len};
    c_next.neg   = b_fl[wwim_pkg::FL_W-1];
    b_mag        = c_next.neg ? (~b_fl + wwim_pkg::FL_W'(1)) : b_fl;
    c_next.mag   = wwim_pkg::MAG_W'(b_mag);
    c_next.rem   = '0;
    c_next.err   = b_err;
    c_next.value = b_value;
    if (c_next.neg) begin
      c_next.clamp = '0;
    end else if (b_fl >= len_fl) begin
      c_next.clamp = len - wwim_pkg::LEN_W'(1);
    end else begin
      c_next.clamp = b_fl[wwim_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c_st <= c_next;
    end
  end

  // --------------------------------------------------------------------------
  // remainder pipeline: restoring, DIV_STEPS magnitude bits per stage
  // --------------------------------------------------------------------------
  function automatic wwim_pkg::div_t div_step(input wwim_pkg::div_t s,
                                              input logic [wwim_pkg::LEN_W-1:0] l);
    wwim_pkg::div_t              r;
    logic [wwim_pkg::LEN_W-1:0]  t;
    r = s;
    for (int i = 0; i < wwim_pkg::DIV_STEPS; i++) begin
      t = {r.rem, r.mag[wwim_pkg::MAG_W-1]};
      if (t >= l) begin
        t = t - l;
      end
      r.rem = t[wwim_pkg::REM_W-1:0];
      r.mag = {r.mag[wwim_pkg::MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < wwim_pkg::DIV_STAGES; k++) begin
      d_in[k]  = (k == 0) ? c_st : d_st[(k == 0) ? 0 : k - 1];
      d_out[k] = div_step(d_in[k], len);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < wwim_pkg::DIV_STAGES; k++) begin
      if (ld[k+3]) begin
        d_st[k] <= d_out[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output stage and table writes
  // --------------------------------------------------------------------------
  always_comb begin
    // negative positions: a nonzero remainder folds back from length
    if (d_st[wwim_pkg::DIV_STAGES-1].neg && d_st[wwim_pkg::DIV_STAGES-1].rem != '0) begin
      wrapped = len - {1'b0, d_st[wwim_pkg::DIV_STAGES-1].rem};
    end else begin
      wrapped = {1'b0, d_st[wwim_pkg::DIV_STAGES-1].rem};
    end
    if (d_st[wwim_pkg::DIV_STAGES-1].err) begin
      out_addr_next = '0;
    end else if (index_mode == wwim_pkg::MODE_LIMIT) begin
      out_addr_next = d_st[wwim_pkg::DIV_STAGES-1].clamp;
    end else begin
      out_addr_next = wrapped;
    end
    out_guard_next = !d_st[wwim_pkg::DIV_STAGES-1].err &&
                     (index_mode == wwim_pkg::MODE_GUARD) && (out_addr_next == '0);
  end

  always_ff @(posedge clk) begin
    if (ld[wwim_pkg::OUT_STG]) begin
      out_addr   <= out_addr_next;
      out_guard  <= out_guard_next;
      out_status <= d_st[wwim_pkg::DIV_STAGES-1].err;
      gaddr      <= len;
      gdata      <= d_st[wwim_pkg::DIV_STAGES-1].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpend <= 1'b0;
    end else begin
      gpend <= ld[wwim_pkg::OUT_STG] && out_guard_next;
    end
  end

  // single write port: the guard copy goes in the cycle after the main write
  always_ff @(posedge clk) begin
    if (gpend) begin
      table_store[gaddr] <= gdata;
    end else if (ld[wwim_pkg::OUT_STG] && !d_st[wwim_pkg::DIV_STAGES-1].err) begin
      table_store[out_addr_next] <= d_st[wwim_pkg::DIV_STAGES-1].value;
    end
  end

  assign result_out.valid         = v[wwim_pkg::OUT_STG];
  assign result_out.write_address = out_addr;
  assign result_out.guard_written = out_guard;
  assign result_out.status        = out_status;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `WWIM_ASSERT_IMPL(a_guard_at_zero, result_out.valid && result_out.guard_written,
                    result_out.write_address == '0 && !result_out.status)
  `WWIM_ASSERT_IMPL(a_err_no_write, result_out.valid && result_out.status,
                    result_out.write_address == '0 && !result_out.guard_written)
  `WWIM_ASSERT_IMPL(a_addr_in_table, result_out.valid && !result_out.status,
                    result_out.write_address < len)
  `WWIM_ASSERT_NEXT(a_guard_blocks, ld[wwim_pkg::OUT_STG] && out_guard_next,
                    gpend && !ld[wwim_pkg::OUT_STG])
  `WWIM_ASSERT_ALWAYS(a_len_legal,
                      len != '0 && len <= wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH))

endmodule

// ===== bench/wavetable_write_with_index_modes_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_write_with_index_modes_tb
// Drives sample writes and register writes into the wavetable write block,
// predicts the entry, guard flag and status of every write, and checks each
// result against it. A short directed table comes first, then random phases
// with random handshake gaps, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module wavetable_write_with_index_modes_tb;

  localparam logic [1:0] MODE_WRAP_ALT = 2'd3;  // unassigned code, behaves as wrap
  localparam logic ST_WRITTEN   = 1'b0;
  localparam logic ST_OFF_RANGE = 1'b1;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DIR_ROWS       = 25;

  typedef struct packed {
    logic [wwim_pkg::ADDR_W-1:0] addr;
    logic                        guard;
    logic                        status;
  } wr_result_t;

  typedef struct packed {
    logic [wwim_pkg::LEN_W-1:0]  len;
    logic                        norm;
    logic [wwim_pkg::IDX_W-1:0]  off;
    logic [1:0]                  mode;
    logic [wwim_pkg::IDX_W-1:0]  idx;
    logic [wwim_pkg::DATA_W-1:0] val;
    logic                        pinned;
    wr_result_t                  want;
  } dir_row_t;

  // pinned rows carry their result; the others go through the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'h0000_0000, 32'h0000_0000,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
      1'b1, '{13'd4095, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'h8000_0000, 32'hA5A5_A5A5,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'h0FFF_FFFF, 32'h5A5A_5A5A,
      1'b1, '{13'd4095, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'hFFFF_FFFF, 32'h0000_0001,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_WRAP,  32'h1000_0000, 32'h8000_0000,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_WRAP,  32'hFFFF_0000, 32'h1234_5678,
      1'b1, '{13'd4095, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_WRAP,  32'hF000_0000, 32'h7FFF_FFFF,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_WRAP,  32'h8000_0000, 32'hDEAD_BEEF,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_GUARD, 32'h0FFF_8000, 32'hCAFE_F00D,
      1'b1, '{13'd0, 1'b1, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_GUARD, 32'h0000_7FFF, 32'h0F0F_0F0F,
      1'b1, '{13'd0, 1'b1, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_GUARD, 32'h0000_8000, 32'hF0F0_F0F0,
      1'b1, '{13'd1, 1'b0, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, wwim_pkg::MODE_GUARD, 32'hFFFF_8000, 32'h3333_3333,
      1'b1, '{13'd0, 1'b1, ST_WRITTEN}},
    '{13'd4096, 1'b0, 32'h0000_0000, MODE_WRAP_ALT, 32'h1000_1234, 32'hCCCC_CCCC,
      1'b1, '{13'd0, 1'b0, ST_WRITTEN}},
    // zero length acts as one entry
    '{13'd0,    1'b0, 32'h0000_0000, wwim_pkg::MODE_GUARD, 32'h1234_5678, 32'h5555_5555,
      1'b1, '{13'd0, 1'b1, ST_WRITTEN}},
    // oversize length acts as full depth
    '{13'd8191, 1'b0, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
      1'b1, '{13'd4095, 1'b0, ST_WRITTEN}},
    '{13'd16,   1'b0, 32'hFFFF_FFFF, wwim_pkg::MODE_LIMIT, 32'h0000_0000, 32'h1111_1111,
      1'b1, '{13'd0, 1'b0, ST_OFF_RANGE}},
    '{13'd16,   1'b0, 32'h0010_0001, wwim_pkg::MODE_LIMIT, 32'h0000_0000, 32'h2222_2222,
      1'b1, '{13'd0, 1'b0, ST_OFF_RANGE}},
    '{13'd16,   1'b0, 32'h0010_0000, wwim_pkg::MODE_LIMIT, 32'h0000_0000, 32'h4444_4444,
      1'b0, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd16,   1'b1, 32'h0001_0000, wwim_pkg::MODE_WRAP,  32'h0000_8000, 32'h6666_6666,
      1'b0, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd16,   1'b1, 32'h0001_0001, wwim_pkg::MODE_WRAP,  32'h0000_8000, 32'h7777_7777,
      1'b1, '{13'd0, 1'b0, ST_OFF_RANGE}},
    '{13'd1,    1'b1, 32'h7FFF_FFFF, wwim_pkg::MODE_WRAP,  32'h0000_0000, 32'h8888_8888,
      1'b1, '{13'd0, 1'b0, ST_OFF_RANGE}},
    '{13'd4096, 1'b1, 32'h8000_0000, wwim_pkg::MODE_WRAP,  32'h0000_0000, 32'h9999_9999,
      1'b1, '{13'd0, 1'b0, ST_OFF_RANGE}},
    '{13'd4096, 1'b1, 32'h0000_0000, wwim_pkg::MODE_LIMIT, 32'hFFFF_FFFF, 32'hBBBB_BBBB,
      1'b0, '{13'd0, 1'b0, ST_WRITTEN}},
    '{13'd2,    1'b0, 32'h0001_8000, wwim_pkg::MODE_GUARD, 32'h7FFF_FFFF, 32'hEEEE_EEEE,
      1'b0, '{13'd0, 1'b0, ST_WRITTEN}}
  };

  logic clk;
  logic rst;

  wwim_sample_if smp_ch ();
  wwim_result_if res_ch ();
  wwim_cfg_if    cfg_ch ();

  wavetable_write_with_index_modes u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (smp_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  // register copy, updated on every config transfer
  logic [wwim_pkg::LEN_W-1:0]        cur_len  = wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH);
  logic                              cur_norm = 1'b0;
  logic signed [wwim_pkg::IDX_W-1:0] cur_off  = '0;
  logic [1:0]                        cur_mode = wwim_pkg::MODE_LIMIT;

  wr_result_t wr_expect_q [$];
  int  mism_cnt    = 0;
  bit  tx_burst    = 1'b0;
  bit  rx_burst    = 1'b0;
  bit  rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint eff_length();
    longint l;
    l = longint'(cur_len);
    if (l < 1) l = 1;
    if (l > wwim_pkg::TABLE_DEPTH) l = wwim_pkg::TABLE_DEPTH;
    return l;
  endfunction

  function automatic wr_result_t predict_write(logic signed [wwim_pkg::IDX_W-1:0] idx);
    wr_result_t r;
    longint len, mul, off, pos, ent;
    r   = '0;
    len = eff_length();
    mul = cur_norm ? len : 64'sd1;
    off = longint'(cur_off) * mul;
    if (off < 0 || off > len * 64'sd65536) begin
      r.status = ST_OFF_RANGE;
      return r;
    end
    pos = longint'(idx) * mul + off;
    if (cur_mode == wwim_pkg::MODE_LIMIT) begin
      ent = pos >>> wwim_pkg::FRAC_W;
      if (ent > len - 1) ent = len - 1;
      else if (ent < 0) ent = 0;
    end else begin
      if (cur_mode == wwim_pkg::MODE_GUARD) pos = pos + 64'sh8000;
      ent = (pos >>> wwim_pkg::FRAC_W) % len;
      if (ent < 0) ent = ent + len;
      r.guard = (cur_mode == wwim_pkg::MODE_GUARD) && (ent == 0);
    end
    r.addr   = ent[wwim_pkg::ADDR_W-1:0];
    r.status = ST_WRITTEN;
    return r;
  endfunction

  // mostly positions within two table spans, with some near entry boundaries
  function automatic logic [wwim_pkg::IDX_W-1:0] pick_index();
    longint span, pos;
    int     k;
    int unsigned u;
    span = cur_norm ? 64'sd65536 : eff_length() * 64'sd65536;
    case ($urandom_range(0, 7))
      0: pos = longint'($urandom);
      1: begin
        k   = $urandom_range(0, 4);
        k   = k - 2;
        u   = $urandom_range(0, 2);
        pos = span * k + longint'(u) * 32768 - 1;
        u   = $urandom_range(0, 2);
        pos = pos + longint'(u);
      end
      default: begin
        u   = $urandom_range(0, 32'(4 * span));
        pos = longint'(u) - 2 * span;
      end
    endcase
    return pos[wwim_pkg::IDX_W-1:0];
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endfunction

  task automatic write_reg(wwim_pkg::cfg_reg_t r, logic [wwim_pkg::DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (r)
      wwim_pkg::REG_TABLE_LENGTH:     cur_len  = d[wwim_pkg::LEN_W-1:0];
      wwim_pkg::REG_INDEX_NORMALIZED: cur_norm = d[0];
      wwim_pkg::REG_WRITE_OFFSET:     cur_off  = d;
      wwim_pkg::REG_INDEX_MODE:       cur_mode = d[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(logic [wwim_pkg::IDX_W-1:0] idx,
                             logic [wwim_pkg::DATA_W-1:0] val,
                             logic pinned, wr_result_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    wr_expect_q.push_back(pinned ? want : predict_write(idx));
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid        <= 1'b1;
    smp_ch.sample_index <= idx;
    smp_ch.sample_value <= val;
    do @(posedge clk); while (!(smp_ch.valid && smp_ch.ready));
  endtask

  // stop offering, then let every outstanding write come back
  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    while (wr_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : rx_side
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  always @(posedge clk) begin
    wr_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (wr_expect_q.size() == 0) begin
        flag_mismatch("unexpected result, write_address", '0,
                      32'(res_ch.write_address));
      end else begin
        want = wr_expect_q.pop_front();
        if (res_ch.write_address !== want.addr)
          flag_mismatch("write_address", 32'(want.addr), 32'(res_ch.write_address));
        if (res_ch.guard_written !== want.guard)
          flag_mismatch("guard_written", 32'(want.guard), 32'(res_ch.guard_written));
        if (res_ch.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(res_ch.status));
      end
    end
  end

  initial begin : stimulus
    dir_row_t                    row;
    int                          sent;
    int                          phase;
    int                          n;
    longint                      l;
    logic [wwim_pkg::LEN_W-1:0]  len_sel;
    logic [wwim_pkg::IDX_W-1:0]  off_sel;
    rst                 <= 1'b1;
    smp_ch.valid        <= 1'b0;
    smp_ch.sample_index <= '0;
    smp_ch.sample_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= wwim_pkg::REG_TABLE_LENGTH;
    cfg_ch.data         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.len !== cur_len || row.norm !== cur_norm || row.off !== cur_off ||
          row.mode !== cur_mode) begin
        wait_drained();
        if (row.len !== cur_len)
          write_reg(wwim_pkg::REG_TABLE_LENGTH, 32'(row.len));
        if (row.norm !== cur_norm)
          write_reg(wwim_pkg::REG_INDEX_NORMALIZED, 32'(row.norm));
        if (row.off !== cur_off)
          write_reg(wwim_pkg::REG_WRITE_OFFSET, row.off);
        if (row.mode !== cur_mode)
          write_reg(wwim_pkg::REG_INDEX_MODE, 32'(row.mode));
      end
      send_sample(row.idx, row.val, row.pinned, row.want);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       len_sel = wwim_pkg::LEN_W'(1);
        1:       len_sel = wwim_pkg::LEN_W'(2);
        2:       len_sel = wwim_pkg::LEN_W'(wwim_pkg::TABLE_DEPTH);
        3:       len_sel = '0;
        4:       len_sel = wwim_pkg::LEN_W'($urandom_range(wwim_pkg::TABLE_DEPTH + 1, 8191));
        5, 6:    len_sel = wwim_pkg::LEN_W'($urandom_range(3, 64));
        default: len_sel = wwim_pkg::LEN_W'($urandom_range(1, wwim_pkg::TABLE_DEPTH));
      endcase
      write_reg(wwim_pkg::REG_TABLE_LENGTH, 32'(len_sel));
      write_reg(wwim_pkg::REG_INDEX_NORMALIZED, 32'($urandom_range(0, 1)));
      l = eff_length();
      // offset: mostly in range, with both range ends and some garbage
      case ($urandom_range(0, 7))
        0:       off_sel = $urandom;
        1:       off_sel = '0;
        2:       off_sel = cur_norm ? 32'h0001_0000 : 32'(l * 65536);
        default: off_sel = cur_norm ? $urandom_range(0, 65536)
                                    : $urandom_range(0, 32'(l * 65536));
      endcase
      write_reg(wwim_pkg::REG_WRITE_OFFSET, off_sel);
      write_reg(wwim_pkg::REG_INDEX_MODE, 32'($urandom_range(0, 3)));

      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // long receiver hold while the sender keeps pushing transfers
        rx_hold_req = 1'b1;
        tx_burst    = 1'b1;
      end
      n = $urandom_range(60, 110);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && phase % 3 == 1) wait_drained();
        send_sample(pick_index(), $urandom, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mism_cnt == 0 && wr_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
